>>> sv/irctok_pkg.sv
// ----------------------------------------------------------------------------
// irctok_pkg
// Shared types and constants for the message tokenizer.
// ----------------------------------------------------------------------------
package irctok_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [4:0] LIMIT_RESET = 5'd14;
	localparam logic [4:0] LIMIT_MAX   = 5'd30;

	localparam logic [7:0] CHAR_COLON  = 8'h3A;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_LOW_A  = 8'h61;
	localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'd32;

	typedef enum logic [1:0] {
		KIND_PREFIX = 2'd0,
		KIND_CMD    = 2'd1,
		KIND_PARAM  = 2'd2
	} field_kind_t;

	typedef enum logic [6:0] {
		PH_START     = 7'b0000001,
		PH_PREFIX    = 7'b0000010,
		PH_CMD_SKIP  = 7'b0000100,
		PH_CMD       = 7'b0001000,
		PH_PARM_SKIP = 7'b0010000,
		PH_PARM_MID  = 7'b0100000,
		PH_PARM_REST = 7'b1000000
	} phase_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0]  raw_byte;
		logic        emit;
		field_kind_t kind;
		logic [4:0]  pidx;
		logic        start;
		logic        last;
		logic [4:0]  total;
		logic        cmd_empty;
		logic        bad;
	} entry_t;

	// queue handshake seen by the front
	typedef struct packed {
		logic push;
		logic full;
	} push_ctl_t;

	// queue handshake seen by the back
	typedef struct packed {
		logic pop;
		logic empty;
	} pop_ctl_t;

endpackage

>>> sv/irctok_in_if.sv
// ----------------------------------------------------------------------------
// irctok_in_if
// Byte channel into the tokenizer: valid, ready, one raw byte and a last-byte flag.
// ----------------------------------------------------------------------------
interface irctok_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> sv/irctok_out_if.sv
// ----------------------------------------------------------------------------
// irctok_out_if
// Result channel out of the tokenizer: tagged byte and end-of-message summary.
// ----------------------------------------------------------------------------
interface irctok_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic [1:0] field_kind;
	logic [4:0] param_index;
	logic       field_start;
	logic       message_end;
	logic [4:0] param_total;
	logic       command_empty;
	logic       malformed;

	modport source (
		output valid, output out_byte, output byte_valid, output field_kind,
		output param_index, output field_start, output message_end,
		output param_total, output command_empty, output malformed,
		input ready
	);
	modport sink (
		input valid, input out_byte, input byte_valid, input field_kind,
		input param_index, input field_start, input message_end,
		input param_total, input command_empty, input malformed,
		output ready
	);
endinterface

>>> sv/irctok_queue.sv
// ----------------------------------------------------------------------------
// irctok_queue
// Small flip-flop queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module irctok_queue
	import irctok_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  entry_t    push_data,
	output logic      full,
	input  logic      pop,
	output entry_t    pop_data,
	output logic      empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	entry_t        slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> sv/irctok_front.sv
// ----------------------------------------------------------------------------
// irctok_front
// Accepts raw bytes, tracks the parse phase and classifies each byte.
// ----------------------------------------------------------------------------
module irctok_front
	import irctok_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [4:0]      cfg_wr_data,
	irctok_in_if.sink       rx,
	output push_ctl_t       push_ctl,
	input  logic            q_full,
	output entry_t          push_data
);

	phase_t      phase_q, phase_d;
	logic [4:0]  cnt_q, cnt_d;
	logic        open_q, open_d;
	logic        seen_q, seen_d;
	logic [4:0]  limit_q;
	logic [4:0]  limit;
	logic        emit;
	field_kind_t kind;
	logic        start;
	logic        is_colon;
	logic        is_space;
	logic        bad;
	logic        accept;

	assign limit    = (limit_q > LIMIT_MAX) ? LIMIT_MAX : limit_q;
	assign is_colon = (rx.data_byte == CHAR_COLON);
	assign is_space = (rx.data_byte == CHAR_SPACE);
	assign rx.ready = !q_full;
	assign accept   = rx.valid && rx.ready;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		open_d  = open_q;
		seen_d  = seen_q;
		emit    = 1'b0;
		kind    = KIND_PREFIX;
		start   = 1'b0;
		unique case (phase_q)
			PH_START: begin
				if (is_colon) begin
					phase_d = PH_PREFIX;
					open_d  = 1'b0;
				end else if (is_space) begin
					phase_d = PH_PARM_SKIP;
				end else begin
					phase_d = PH_CMD;
					open_d  = 1'b0;
					emit    = 1'b1;
					kind    = KIND_CMD;
				end
			end
			PH_PREFIX: begin
				if (is_space) begin
					phase_d = PH_CMD_SKIP;
				end else begin
					emit = 1'b1;
					kind = KIND_PREFIX;
				end
			end
			PH_CMD_SKIP: begin
				if (!is_space) begin
					phase_d = PH_CMD;
					open_d  = 1'b0;
					emit    = 1'b1;
					kind    = KIND_CMD;
				end
			end
			PH_CMD: begin
				if (is_space) begin
					phase_d = PH_PARM_SKIP;
				end else begin
					emit = 1'b1;
					kind = KIND_CMD;
				end
			end
			PH_PARM_SKIP: begin
				if (is_colon) begin
					cnt_d   = cnt_q + 5'd1;
					phase_d = PH_PARM_REST;
					open_d  = 1'b0;
				end else if (!is_space) begin
					phase_d = (cnt_q < limit) ? PH_PARM_MID : PH_PARM_REST;
					cnt_d   = cnt_q + 5'd1;
					open_d  = 1'b0;
					emit    = 1'b1;
					kind    = KIND_PARAM;
				end
			end
			PH_PARM_MID: begin
				if (is_space) begin
					phase_d = PH_PARM_SKIP;
				end else begin
					emit = 1'b1;
					kind = KIND_PARAM;
				end
			end
			PH_PARM_REST: begin
				emit = 1'b1;
				kind = KIND_PARAM;
			end
			default: begin
				phase_d = PH_START;
				cnt_d   = '0;
				open_d  = 1'b0;
				seen_d  = 1'b0;
			end
		endcase
		if (emit) begin
			if (kind == KIND_CMD) begin
				seen_d = 1'b1;
			end
			start  = !open_d;
			open_d = 1'b1;
		end
	end

	assign bad = (phase_d == PH_PREFIX);

	always_comb begin
		push_data.raw_byte  = rx.data_byte;
		push_data.emit      = emit;
		push_data.kind      = kind;
		push_data.pidx      = (kind == KIND_PARAM) ? cnt_d - 5'd1 : '0;
		push_data.start     = start;
		push_data.last      = rx.last_byte;
		push_data.total     = bad ? '0 : cnt_d;
		push_data.cmd_empty = bad || !seen_d;
		push_data.bad       = bad;
	end

	assign push_ctl.push = accept && (emit || rx.last_byte);
	assign push_ctl.full = q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			cnt_q   <= '0;
			open_q  <= 1'b0;
			seen_q  <= 1'b0;
			limit_q <= LIMIT_RESET;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (accept) begin
				if (rx.last_byte) begin
					phase_q <= PH_START;
					cnt_q   <= '0;
					open_q  <= 1'b0;
					seen_q  <= 1'b0;
				end else begin
					phase_q <= phase_d;
					cnt_q   <= cnt_d;
					open_q  <= open_d;
					seen_q  <= seen_d;
				end
			end
		end
	end

endmodule

>>> sv/irctok_back.sv
// ----------------------------------------------------------------------------
// irctok_back
// Drains the queue, forms the final result and holds it in the output register.
// ----------------------------------------------------------------------------
module irctok_back
	import irctok_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  entry_t        q_data,
	input  logic          q_empty,
	output pop_ctl_t      pop_ctl,
	irctok_out_if.source  tx
);

	logic       valid_q;
	logic       load;
	logic       is_lower;
	logic [7:0] byte_q;
	logic       bvalid_q;
	logic [1:0] kind_q;
	logic [4:0] pidx_q;
	logic       start_q;
	logic       end_q;
	logic [4:0] total_q;
	logic       cempty_q;
	logic       bad_q;

	assign load     = !q_empty && (!valid_q || tx.ready);
	assign is_lower = (q_data.raw_byte >= CHAR_LOW_A) && (q_data.raw_byte <= CHAR_LOW_Z);

	assign pop_ctl.pop   = load;
	assign pop_ctl.empty = q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (tx.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bvalid_q <= q_data.emit;
			end_q    <= q_data.last;
			if (q_data.emit) begin
				byte_q  <= (q_data.kind == KIND_CMD && is_lower) ?
					q_data.raw_byte - CASE_OFFSET : q_data.raw_byte;
				kind_q  <= q_data.kind;
				pidx_q  <= q_data.pidx;
				start_q <= q_data.start;
			end else begin
				byte_q  <= '0;
				kind_q  <= '0;
				pidx_q  <= '0;
				start_q <= 1'b0;
			end
			if (q_data.last) begin
				total_q  <= q_data.total;
				cempty_q <= q_data.cmd_empty;
				bad_q    <= q_data.bad;
			end else begin
				total_q  <= '0;
				cempty_q <= 1'b0;
				bad_q    <= 1'b0;
			end
		end
	end

	assign tx.valid         = valid_q;
	assign tx.out_byte      = byte_q;
	assign tx.byte_valid    = bvalid_q;
	assign tx.field_kind    = kind_q;
	assign tx.param_index   = pidx_q;
	assign tx.field_start   = start_q;
	assign tx.message_end   = end_q;
	assign tx.param_total   = total_q;
	assign tx.command_empty = cempty_q;
	assign tx.malformed     = bad_q;

endmodule

>>> sv/irc_message_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// irc_message_tokenizer_unit
// Streaming tokenizer that tags message bytes as prefix, command or parameter.
// ----------------------------------------------------------------------------
// The unit takes one byte per cycle on rx while its queue is not full and
// returns at most one result per byte on tx: one for every content byte and
// one for the last byte of each message, which also carries the summary.
// Separator bytes make no result. An accepted byte passes the queue and the
// output register before it shows on tx; the front updates its phase register
// per byte, and QUEUE_DEPTH queue entries plus the output register let rx
// keep moving while tx is stalled. The user must write middle_param_limit
// through cfg_wr_en and cfg_wr_data only while the unit is idle, which the
// unit does not enforce; it resets to 14 and values above 30 act as 30.
module irc_message_tokenizer_unit
	import irctok_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [4:0]    cfg_wr_data,
	irctok_in_if.sink     rx,
	irctok_out_if.source  tx
);

	push_ctl_t push_ctl;
	pop_ctl_t  pop_ctl;
	entry_t    push_data;
	entry_t    pop_data;
	logic      q_full;
	logic      q_empty;

	irctok_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rx          (rx),
		.push_ctl    (push_ctl),
		.q_full      (q_full),
		.push_data   (push_data)
	);

	irctok_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_ctl.push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop_ctl.pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	irctok_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (pop_data),
		.q_empty (q_empty),
		.pop_ctl (pop_ctl),
		.tx      (tx)
	);

	// a result without content is always the end of a message
	assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && !tx.byte_valid |-> tx.message_end)
		else $error("non-content result without message end");

	// a malformed prefix reports no command and no parameters
	assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.message_end && tx.malformed |->
			tx.command_empty && tx.param_total == 5'd0)
		else $error("malformed summary inconsistent");

	// only parameter bytes carry a parameter index
	assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.field_kind != KIND_PARAM |-> tx.param_index == 5'd0)
		else $error("parameter index on non-parameter byte");

	// the front never pushes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		push_ctl.push |-> !push_ctl.full)
		else $error("push into full queue");

	// the back never pops an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		pop_ctl.pop |-> !pop_ctl.empty)
		else $error("pop from empty queue");

endmodule

>>> tb/sv/irc_message_tokenizer_unit_checker.sv
// ----------------------------------------------------------------------------
// irc_message_tokenizer_unit_checker
// Watches the byte and result channels and the limit register write port,
// predicts the tagged result of every accepted byte that makes one, and
// compares each returned result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module irc_message_tokenizer_unit_checker
	import irctok_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [4:0] cfg_wr_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       byte_valid,
	input  logic [1:0] field_kind,
	input  logic [4:0] param_index,
	input  logic       field_start,
	input  logic       message_end,
	input  logic [4:0] param_total,
	input  logic       command_empty,
	input  logic       malformed,
	output int         pending,
	output int         errors,
	output int         results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]  text;
		logic        content;
		field_kind_t kind;
		logic [4:0]  pidx;
		logic        first;
		logic        msg_end;
		logic [4:0]  total;
		logic        no_cmd;
		logic        bad;
	} token_t;

	token_t     expected_tokens[$];
	token_t     want_tok;
	token_t     new_tok;
	phase_t     scan_phase   = PH_START;
	logic [4:0] params_found = '0;
	logic       in_field     = 1'b0;
	logic       saw_command  = 1'b0;
	logic [4:0] split_limit  = LIMIT_RESET;
	int         fail_total   = 0;
	int         checked      = 0;

	task automatic flag_mismatch(input string what, input int got, input int want);
		fail_total++;
		$display("mismatch on result %0d: %s is %0d, expected %0d", checked, what, got, want);
	endtask

	function automatic void clear_scan();
		scan_phase   = PH_START;
		params_found = '0;
		in_field     = 1'b0;
		saw_command  = 1'b0;
	endfunction

	function automatic bit tokenize_byte(input logic [7:0] b, input logic last, output token_t tok);
		logic       emit;
		logic [4:0] lim;
		logic       bad;
		emit = 1'b0;
		tok  = '0;
		lim  = (split_limit > LIMIT_MAX) ? LIMIT_MAX : split_limit;
		case (scan_phase)
			PH_START: begin
				if (b == CHAR_COLON) begin
					scan_phase = PH_PREFIX;
					in_field   = 1'b0;
				end else if (b == CHAR_SPACE) begin
					scan_phase = PH_PARM_SKIP;
				end else begin
					scan_phase = PH_CMD;
					in_field   = 1'b0;
					emit       = 1'b1;
					tok.kind   = KIND_CMD;
				end
			end
			PH_PREFIX: begin
				if (b == CHAR_SPACE) begin
					scan_phase = PH_CMD_SKIP;
				end else begin
					emit     = 1'b1;
					tok.kind = KIND_PREFIX;
				end
			end
			PH_CMD_SKIP: begin
				if (b != CHAR_SPACE) begin
					scan_phase = PH_CMD;
					in_field   = 1'b0;
					emit       = 1'b1;
					tok.kind   = KIND_CMD;
				end
			end
			PH_CMD: begin
				if (b == CHAR_SPACE) begin
					scan_phase = PH_PARM_SKIP;
				end else begin
					emit     = 1'b1;
					tok.kind = KIND_CMD;
				end
			end
			PH_PARM_SKIP: begin
				if (b == CHAR_COLON) begin
					params_found = params_found + 5'd1;
					scan_phase   = PH_PARM_REST;
					in_field     = 1'b0;
				end else if (b != CHAR_SPACE) begin
					scan_phase   = (params_found < lim) ? PH_PARM_MID : PH_PARM_REST;
					params_found = params_found + 5'd1;
					in_field     = 1'b0;
					emit         = 1'b1;
					tok.kind     = KIND_PARAM;
				end
			end
			PH_PARM_MID: begin
				if (b == CHAR_SPACE) begin
					scan_phase = PH_PARM_SKIP;
				end else begin
					emit     = 1'b1;
					tok.kind = KIND_PARAM;
				end
			end
			PH_PARM_REST: begin
				emit     = 1'b1;
				tok.kind = KIND_PARAM;
			end
			default: begin
				clear_scan();
			end
		endcase

		if (emit) begin
			tok.content = 1'b1;
			tok.text    = b;
			if (tok.kind == KIND_CMD) begin
				saw_command = 1'b1;
				if (b >= CHAR_LOW_A && b <= CHAR_LOW_Z) begin
					tok.text = b - CASE_OFFSET;
				end
			end
			if (tok.kind == KIND_PARAM) begin
				tok.pidx = params_found - 5'd1;
			end
			tok.first = !in_field;
			in_field  = 1'b1;
		end else begin
			tok.kind = KIND_PREFIX;
		end

		if (!emit && !last) begin
			return 1'b0;
		end
		if (last) begin
			bad         = (scan_phase == PH_PREFIX);
			tok.msg_end = 1'b1;
			tok.total   = bad ? 5'd0 : params_found;
			tok.no_cmd  = bad || !saw_command;
			tok.bad     = bad;
			clear_scan();
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_tokens.delete();
			clear_scan();
			split_limit = LIMIT_RESET;
		end else begin
			// a result passes the queue and output register after its byte, so check before predicting
			if (out_valid && out_ready) begin
				if (expected_tokens.size() == 0) begin
					flag_mismatch("result with nothing pending", 1, 0);
				end else begin
					want_tok = expected_tokens.pop_front();
					if (out_byte !== want_tok.text)
						flag_mismatch("out_byte", out_byte, want_tok.text);
					if (byte_valid !== want_tok.content)
						flag_mismatch("byte_valid", byte_valid, want_tok.content);
					if (field_kind !== want_tok.kind)
						flag_mismatch("field_kind", field_kind, want_tok.kind);
					if (param_index !== want_tok.pidx)
						flag_mismatch("param_index", param_index, want_tok.pidx);
					if (field_start !== want_tok.first)
						flag_mismatch("field_start", field_start, want_tok.first);
					if (message_end !== want_tok.msg_end)
						flag_mismatch("message_end", message_end, want_tok.msg_end);
					if (param_total !== want_tok.total)
						flag_mismatch("param_total", param_total, want_tok.total);
					if (command_empty !== want_tok.no_cmd)
						flag_mismatch("command_empty", command_empty, want_tok.no_cmd);
					if (malformed !== want_tok.bad)
						flag_mismatch("malformed", malformed, want_tok.bad);
				end
				checked++;
			end
			if (in_valid && in_ready) begin
				if (tokenize_byte(in_byte, in_last, new_tok)) begin
					expected_tokens.insert(expected_tokens.size(), new_tok);
				end
			end
			if (cfg_wr_en) begin
				split_limit = cfg_wr_data;
			end
		end
		pending      <= expected_tokens.size();
		errors       <= fail_total;
		results_seen <= checked;
	end
endmodule

>>> tb/sv/irc_message_tokenizer_unit_tb.sv
// ----------------------------------------------------------------------------
// irc_message_tokenizer_unit_tb
// Drives the tokenizer with a few directed messages, then random well-formed,
// truncated and noise messages under several split limits and pacing mixes,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module irc_message_tokenizer_unit_tb
	import irctok_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 4000;
	localparam int PHASE_BYTES   = 200;
	localparam int NUM_PHASES    = 8;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [4:0] cfg_wr_data;

	irctok_in_if  rx_ch ();
	irctok_out_if tx_ch ();

	int         pending;
	int         errors;
	int         results_seen;
	int         idle_pct      = 0;
	int         stall_pct     = 0;
	int         stall_cycles  = 0;
	int         bytes_sent    = 0;
	int         messages_sent = 0;
	int         target;
	logic [4:0] next_limit;
	logic [7:0] msg_q[$];

	irc_message_tokenizer_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rx          (rx_ch),
		.tx          (tx_ch)
	);

	irc_message_tokenizer_unit_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (rx_ch.valid),
		.in_ready      (rx_ch.ready),
		.in_byte       (rx_ch.data_byte),
		.in_last       (rx_ch.last_byte),
		.out_valid     (tx_ch.valid),
		.out_ready     (tx_ch.ready),
		.out_byte      (tx_ch.out_byte),
		.byte_valid    (tx_ch.byte_valid),
		.field_kind    (tx_ch.field_kind),
		.param_index   (tx_ch.param_index),
		.field_start   (tx_ch.field_start),
		.message_end   (tx_ch.message_end),
		.param_total   (tx_ch.param_total),
		.command_empty (tx_ch.command_empty),
		.malformed     (tx_ch.malformed),
		.pending       (pending),
		.errors        (errors),
		.results_seen  (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		tx_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			tx_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (rx_ch.valid && rx_ch.ready) || (tx_ch.valid && tx_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("no transfer for %0d cycles, %0d results still pending", STALL_LIMIT, pending);
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [7:0] word_char(input bit first);
		logic [7:0] c;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 50) return CHAR_LOW_A + 8'($urandom_range(25));
		if (pick < 70) return 8'h41 + 8'($urandom_range(25));
		if (pick < 80) return 8'h30 + 8'($urandom_range(9));
		do begin
			c = 8'($urandom_range(255));
		end while (c == CHAR_SPACE || (first && c == CHAR_COLON));
		return c;
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		msg_q.insert(msg_q.size(), b);
	endfunction

	function automatic void add_word(input int max_len);
		int n;
		n = $urandom_range(max_len, 1);
		for (int i = 0; i < n; i++) begin
			add_byte(word_char(i == 0));
		end
	endfunction

	function automatic void add_spaces();
		repeat ($urandom_range(99) < 85 ? 1 : $urandom_range(3, 2)) add_byte(CHAR_SPACE);
	endfunction

	function automatic void build_message();
		int pick;
		int nparams;
		int wlen;
		int cut;
		msg_q.delete();
		if ($urandom_range(99) < 22) begin
			repeat ($urandom_range(12, 1)) begin
				pick = $urandom_range(99);
				if (pick < 30) add_byte(CHAR_SPACE);
				else if (pick < 45) add_byte(CHAR_COLON);
				else add_byte(8'($urandom_range(255)));
			end
			return;
		end
		if ($urandom_range(99) < 35) begin
			add_byte(CHAR_COLON);
			add_word(8);
			add_spaces();
		end else if ($urandom_range(99) < 10) begin
			add_spaces();
		end
		if ($urandom_range(99) < 95) add_word(7);
		if ($urandom_range(99) < 12) begin
			nparams = $urandom_range(34, 28);
			wlen    = 2;
		end else begin
			nparams = $urandom_range(5, 0);
			wlen    = 6;
		end
		repeat (nparams) begin
			add_spaces();
			add_word(wlen);
		end
		if ($urandom_range(99) < 45) begin
			add_spaces();
			add_byte(CHAR_COLON);
			repeat ($urandom_range(3, 0)) begin
				add_word(5);
				if ($urandom_range(1)) add_byte(CHAR_SPACE);
			end
		end
		if ($urandom_range(99) < 8) add_byte(CHAR_SPACE);
		if (msg_q.size() == 0) add_byte(word_char(1'b1));
		// broken sequence: cut the line short
		if ($urandom_range(99) < 15) begin
			cut = $urandom_range(msg_q.size(), 1);
			while (msg_q.size() > cut) void'(msg_q.pop_back());
		end
	endfunction

	task automatic send_message();
		for (int i = 0; i < msg_q.size(); i++) begin
			while ($urandom_range(99) < idle_pct) begin
				rx_ch.valid <= 1'b0;
				@(posedge clk);
			end
			rx_ch.valid     <= 1'b1;
			rx_ch.data_byte <= msg_q[i];
			rx_ch.last_byte <= (i == msg_q.size() - 1);
			@(posedge clk);
			while (!rx_ch.ready) @(posedge clk);
			bytes_sent++;
		end
		messages_sent++;
	endtask

	task automatic send_text(input string s);
		msg_q.delete();
		for (int i = 0; i < s.len(); i++) begin
			add_byte(s[i]);
		end
		send_message();
	endtask

	// hold the sender until every predicted result has come back
	task automatic drain();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_split_limit(input logic [4:0] value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		rx_ch.valid     = 1'b0;
		rx_ch.data_byte = '0;
		rx_ch.last_byte = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed messages at the reset limit
		send_text(":p `az{ c :d e");
		send_text(" x");
		send_text("q :");
		send_text(":ab");
		msg_q = '{8'h00};
		send_message();
		msg_q = '{8'hFF};
		send_message();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: next_limit = 5'd0;
				1: next_limit = 5'd31;
				2: next_limit = LIMIT_MAX;
				3: next_limit = 5'd1;
				4: next_limit = 5'd3;
				5: next_limit = 5'($urandom_range(31));
				6: next_limit = LIMIT_RESET;
				default: next_limit = 5'd2;
			endcase
			write_split_limit(next_limit);
			case ((p + 1) % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 80; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 80; end
				default: begin idle_pct = 28; stall_pct = 28; end
			endcase
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				build_message();
				send_message();
			end
		end

		drain();
		$display("run covered %0d messages, %0d bytes and %0d checked results",
			messages_sent, bytes_sent, results_seen);
		$display("split limits 0 to 31 incl. both ends; sender and receiver idling 0, 28, 80 pct");
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

>>> sim.f
sv/irctok_pkg.sv
sv/irctok_in_if.sv
sv/irctok_out_if.sv
sv/irctok_queue.sv
sv/irctok_front.sv
sv/irctok_back.sv
sv/irc_message_tokenizer_unit.sv
tb/sv/irc_message_tokenizer_unit_checker.sv
tb/sv/irc_message_tokenizer_unit_tb.sv
